/* src/pseudocost_branch_select_defines.svh */
// Assertion macros for the branch selection block.
`ifndef PSEUDOCOST_BRANCH_SELECT_DEFINES_SVH
`define PSEUDOCOST_BRANCH_SELECT_DEFINES_SVH
`ifndef SYNTHESIS
`define PBS_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PBS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define PBS_ASSERT_IMPL(label, clk, rst_n, a, c)
`define PBS_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* src/pbs_pkg.sv */
`default_nettype none
package pbs_pkg;
    localparam int FB = 16;
    localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;

    localparam logic [2:0] CFG_AVG_DOWN  = 3'd0;
    localparam logic [2:0] CFG_AVG_UP    = 3'd1;
    localparam logic [2:0] CFG_ROOT_LIM  = 3'd2;
    localparam logic [2:0] CFG_LOW_FRAC  = 3'd3;
    localparam logic [2:0] CFG_HIGH_FRAC = 3'd4;
    localparam logic [2:0] CFG_TIE_TOL   = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture input item
        logic div_init;  // start a division
        logic [1:0] div_sel; // 0 down mean, 1 up mean, 2 score
        logic div_step;  // one quotient bit
        logic div_done;  // store quotient
        logic sqrt_init;
        logic sqrt_step;
        logic decide;    // pick direction, load multiplier and sqrt operands
        logic mul_hi;    // sum the partial products into the product
        logic update;    // compare and keep best; present result on the last candidate
        logic emit;      // unused; results are presented by update
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic sqrt_last;
        logic last;
        logic out_busy;
    } t_sts;

    localparam logic [1:0] DSEL_DOWN  = 2'd0;
    localparam logic [1:0] DSEL_UP    = 2'd1;
    localparam logic [1:0] DSEL_SCORE = 2'd2;
endpackage
`default_nettype wire

/* src/pseudocost_branch_select.sv */
// Sequence: after an input is accepted, the down and up means are divided
// on one shared restoring divider, the direction is decided, a square root
// is taken, the product is formed, the score is divided on the same divider
// and the best is updated. A new item is taken only when the controller is
// idle and no result waits at the output, so items are not overlapped.
// Reset: synchronous, active low; clears the best-candidate state and loads
// configuration defaults.
`default_nettype none
module pseudocost_branch_select
    import pbs_pkg::*;
#(
    parameter int IDX_W = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [47:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_var_index,
    input  wire logic [47:0] i_lp_value,
    input  wire logic [47:0] i_root_value,
    input  wire logic [47:0] i_down_sum,
    input  wire logic [15:0] i_down_count,
    input  wire logic [47:0] i_up_sum,
    input  wire logic [15:0] i_up_count,
    input  wire logic        i_last_candidate,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_chosen_index,
    output logic             o_round_up,
    output logic [47:0]      o_best_score
);
    t_cmd w_cmd;
    t_sts w_sts;

    // The controller sequences means, square root, product and score division.
    pbs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    pbs_datapath #(.IDX_W(IDX_W)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_var_index(i_var_index), .i_lp_value(i_lp_value),
        .i_root_value(i_root_value), .i_down_sum(i_down_sum),
        .i_down_count(i_down_count), .i_up_sum(i_up_sum),
        .i_up_count(i_up_count), .i_last_candidate(i_last_candidate),
        .i_out_ready(i_out_ready), .o_out_valid(o_out_valid),
        .o_chosen_index(o_chosen_index), .o_round_up(o_round_up),
        .o_best_score(o_best_score)
    );
endmodule
`default_nettype wire

/* src/pbs_datapath.sv */
`default_nettype none
module pbs_datapath
    import pbs_pkg::*;
#(
    parameter int IDX_W = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [47:0] i_cfg_data,
    input  wire logic [15:0] i_var_index,
    input  wire logic [47:0] i_lp_value,
    input  wire logic [47:0] i_root_value,
    input  wire logic [47:0] i_down_sum,
    input  wire logic [15:0] i_down_count,
    input  wire logic [47:0] i_up_sum,
    input  wire logic [15:0] i_up_count,
    input  wire logic        i_last_candidate,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [15:0]      o_chosen_index,
    output logic             o_round_up,
    output logic [47:0]      o_best_score
);
    logic [47:0] r_avg_dn, r_avg_up;
    logic [23:0] r_root_lim;
    logic [15:0] r_low_lim, r_high_lim, r_tie;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_dn <= '0;
            r_avg_up <= '0;
            r_root_lim <= 24'd26214;
            r_low_lim <= 16'd19661;
            r_high_lim <= 16'd45875;
            r_tie <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_AVG_DOWN:  r_avg_dn <= i_cfg_data;
                CFG_AVG_UP:    r_avg_up <= i_cfg_data;
                CFG_ROOT_LIM:  r_root_lim <= i_cfg_data[23:0];
                CFG_LOW_FRAC:  r_low_lim <= i_cfg_data[15:0];
                CFG_HIGH_FRAC: r_high_lim <= i_cfg_data[15:0];
                CFG_TIE_TOL:   r_tie <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Captured item.
    logic [IDX_W-1:0] r_idx;
    logic [47:0] r_lp, r_root, r_dsum, r_usum;
    logic [15:0] r_dcnt, r_ucnt;
    logic r_last;
    logic [48:0] r_pcd, r_pcu; // 48-bit means, extra bit unused headroom avoided below

    // Shared restoring divider: 96-bit dividend, 50-bit divisor.
    logic [95:0] r_dvd;
    logic [50:0] r_rem;
    logic [49:0] r_dvs;
    logic [95:0] r_quo;
    logic [6:0]  r_dcnt_bits;
    logic        r_ovf;

    // Sqrt unit.
    logic [31:0] r_sq_v, r_sq_r, r_sq_bit;
    logic [24:0] r_sqrt;
    logic [31:0] sqrt_src_hold;

    // Multiply result.
    logic [49:0] r_mb;
    logic [74:0] r_prod;
    logic [24:0] r_ma;
    logic        r_dir;
    logic [47:0] r_score;

    logic [47:0] r_best_score;
    logic [IDX_W-1:0] r_best_idx;
    logic r_best_dir, r_have;
    logic r_ov;
    logic [15:0] r_o_idx;
    logic r_o_dir;
    logic [47:0] r_o_score;

    logic [15:0] w_fd;
    assign w_fd = r_lp[15:0];

    logic [50:0] w_trial;
    logic [50:0] w_rem_sh;
    assign w_rem_sh = {r_rem[49:0], r_dvd[95]};
    assign w_trial  = w_rem_sh - {1'b0, r_dvs};

    logic [31:0] w_sq_t;
    assign w_sq_t = r_sq_r + r_sq_bit;

    // Two 25 by 25 partial products of the score numerator.
    logic [49:0] w_pp_lo, w_pp_hi;
    assign w_pp_lo = {25'd0, r_ma} * {25'd0, r_mb[24:0]};
    assign w_pp_hi = {25'd0, r_ma} * {25'd0, r_mb[49:25]};

    // Direction decision.
    logic signed [49:0] w_lp, w_rt, w_lim;
    logic w_up;
    always_comb begin
        w_lp  = {{2{r_lp[47]}}, r_lp};
        w_rt  = {{2{r_root[47]}}, r_root};
        w_lim = {26'd0, r_root_lim};
        if (w_lp < w_rt - w_lim) w_up = 1'b0;
        else if (w_lp > w_rt + w_lim) w_up = 1'b1;
        else if (w_fd < r_low_lim) w_up = 1'b0;
        else if (w_fd > r_high_lim) w_up = 1'b1;
        else if ({1'b0, r_pcd[47:0]} < {1'b0, r_pcu[47:0]} + {33'd0, r_tie}) w_up = 1'b0;
        else w_up = 1'b1;
    end

    // The sqrt operand is captured when the direction is decided.
    logic [31:0] w_sq_src;
    always_comb begin
        w_sq_src = '0;
        if (w_fd != 16'd0) w_sq_src = w_up ? {w_fd, 16'd0} : {16'(17'h10000 - {1'b0, w_fd}), 16'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx  <= i_var_index[IDX_W-1:0];
            r_lp   <= i_lp_value;
            r_root <= i_root_value;
            r_dsum <= i_down_sum;
            r_usum <= i_up_sum;
            r_dcnt <= i_down_count;
            r_ucnt <= i_up_count;
            r_last <= i_last_candidate;
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= '0;
            r_dcnt_bits <= '0;
            r_ovf <= 1'b0;
            case (i_cmd.div_sel)
                DSEL_DOWN: begin
                    r_dvd <= {48'd0, r_dsum};
                    r_dvs <= {34'd0, (r_dcnt == 16'd0) ? 16'd1 : r_dcnt};
                end
                DSEL_UP: begin
                    r_dvd <= {48'd0, r_usum};
                    r_dvs <= {34'd0, (r_ucnt == 16'd0) ? 16'd1 : r_ucnt};
                end
                default: begin
                    r_dvd <= {21'd0, r_prod};
                    r_dvs <= r_dir ? (50'd65536 + {1'b0, r_pcu}) : (50'd65536 + {1'b0, r_pcd});
                end
            endcase
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[94:0], 1'b0};
            r_dcnt_bits <= r_dcnt_bits + 7'd1;
            if (!w_trial[50]) begin
                r_rem <= w_trial;
                r_quo <= {r_quo[94:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_quo <= {r_quo[94:0], 1'b0};
            end
        end
        if (i_cmd.div_done) begin
            case (i_cmd.div_sel)
                DSEL_DOWN: r_pcd <= (r_dcnt == 16'd0) ? {1'b0, r_avg_dn} : {1'b0, r_quo[47:0]};
                DSEL_UP:   r_pcu <= (r_ucnt == 16'd0) ? {1'b0, r_avg_up} : {1'b0, r_quo[47:0]};
                default:   r_score <= (r_quo[95:48] != '0) ? SAT48 : r_quo[47:0];
            endcase
        end
        if (i_cmd.sqrt_init) begin
            r_sq_v <= sqrt_src_hold;
            r_sq_r <= '0;
            r_sq_bit <= 32'h4000_0000;
        end else if (i_cmd.sqrt_step) begin
            r_sq_bit <= r_sq_bit >> 2;
            if (r_sq_v >= w_sq_t) begin
                r_sq_v <= r_sq_v - w_sq_t;
                r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
            end else begin
                r_sq_r <= r_sq_r >> 1;
            end
        end
        if (i_cmd.decide) begin
            r_dir <= w_up;
            r_ma  <= r_sq_r[24:0];
            r_mb  <= w_up ? (50'd65536 + {1'b0, r_pcd}) : (50'd65536 + {1'b0, r_pcu});
            sqrt_src_hold <= w_sq_src;
        end
        if (i_cmd.mul_hi) begin
            r_prod <= {25'd0, w_pp_lo} + {w_pp_hi, 25'd0};
        end
    end

    assign o_sts.div_last  = (r_dcnt_bits == 7'd95);
    assign o_sts.sqrt_last = (r_sq_bit == 32'd1);
    assign o_sts.last      = r_last;
    assign o_sts.out_busy  = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_best_score <= '0;
            r_best_idx <= '0;
            r_best_dir <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_out_ready) r_ov <= 1'b0;
            if (i_cmd.update) begin
                if (r_last) begin
                    r_ov <= 1'b1;
                    r_have <= 1'b0;
                    r_best_score <= '0;
                    r_best_idx <= '0;
                    r_best_dir <= 1'b0;
                    if (!r_have || r_score > r_best_score) begin
                        r_o_idx <= 16'(r_idx);
                        r_o_dir <= r_dir;
                        r_o_score <= r_score;
                    end else begin
                        r_o_idx <= 16'(r_best_idx);
                        r_o_dir <= r_best_dir;
                        r_o_score <= r_best_score;
                    end
                end else if (!r_have || r_score > r_best_score) begin
                    r_have <= 1'b1;
                    r_best_score <= r_score;
                    r_best_idx <= r_idx;
                    r_best_dir <= r_dir;
                end
            end
        end
    end

    assign o_out_valid    = r_ov;
    assign o_chosen_index = r_o_idx;
    assign o_round_up     = r_o_dir;
    assign o_best_score   = r_o_score;
endmodule
`default_nettype wire

/* src/pbs_ctrl.sv */
`default_nettype none
`include "pseudocost_branch_select_defines.svh"
module pbs_ctrl
    import pbs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DINIT = 10'b0000000010,
        S_DRUN  = 10'b0000000100,
        S_SQI   = 10'b0000001000,
        S_SQR   = 10'b0000010000,
        S_MUL   = 10'b0000100000,
        S_SINIT = 10'b0001000000,
        S_SRUN  = 10'b0010000000,
        S_UPD   = 10'b0100000000,
        S_DEC   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel <= DSEL_DOWN;
        end else begin
            r_state <= n_state;
            r_sel <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel = r_sel;
        o_cmd = '0;
        o_cmd.div_sel = r_sel;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !i_sts.out_busy;
                if (i_in_valid && !i_sts.out_busy) begin
                    o_cmd.load = 1'b1;
                    n_sel = DSEL_DOWN;
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DRUN;
            end
            S_DRUN: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_SQI;
            end
            S_SQI: begin
                o_cmd.div_done = 1'b1;
                if (r_sel == DSEL_DOWN) begin
                    n_sel = DSEL_UP;
                    n_state = S_DINIT;
                end else if (r_sel == DSEL_UP) begin
                    n_state = S_DEC;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state = S_SINIT;
            end
            S_SINIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_state = S_SRUN;
            end
            S_SRUN: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_last) n_state = S_SQR;
            end
            S_SQR: begin
                o_cmd.decide = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_hi = 1'b1;
                n_sel = DSEL_SCORE;
                n_state = S_DINIT;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    `PBS_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE)
    `PBS_ASSERT_NEXT(a_load_div, i_clk, i_rst_n, o_cmd.load, r_state == S_DINIT)
    `PBS_ASSERT_IMPL(a_upd_score, i_clk, i_rst_n, o_cmd.update, r_sel == DSEL_SCORE)
endmodule
`default_nettype wire
